// ===== rtl/matrix3_inverse_adjugate_macros.svh =====
// ---------------------------------------------------------------------------
// matrix3 inverse assertion macros
// concurrent check helpers, compiled out with NO_ASSERTIONS
// ---------------------------------------------------------------------------
`ifndef MATRIX3_INVERSE_ADJUGATE_MACROS_SVH
`define MATRIX3_INVERSE_ADJUGATE_MACROS_SVH

`ifndef NO_ASSERTIONS
`define M3INV_ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("m3inv check failed");
`define M3INV_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("m3inv check failed");
`else
`define M3INV_ASSERT_SAME(lbl, ante, cons)
`define M3INV_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

// ===== rtl/m3inv_pkg.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// m3inv_pkg
// widths, types and cofactor index tables for the 3x3 inverse pipeline
// ---------------------------------------------------------------------------
package m3inv_pkg;

  localparam int ELEM_W    = 32;
  localparam int FRAC_W    = 16;
  localparam int N_ELEM    = 9;
  localparam int N_ROW     = 3;
  localparam int PROD_W    = 2 * ELEM_W;
  localparam int ADJ_W     = PROD_W + 1;
  localparam int ADJ_LO_W  = ADJ_W - ELEM_W;
  localparam int PL_W      = ELEM_W + ADJ_LO_W + 1;
  localparam int DET_W     = ELEM_W + ADJ_W + 2;
  localparam int NUM_W     = ADJ_W + 2 * FRAC_W;
  localparam int DEN_W     = DET_W;
  localparam int Q_W       = ELEM_W;
  localparam int CMP_W     = DEN_W + Q_W;
  localparam int DIV_STEPS = Q_W + 1;
  localparam int TDATA_W   = N_ELEM * ELEM_W;
  localparam int TUSER_W   = 2;

  localparam logic [ELEM_W-1:0] ELEM_MAX = {1'b0, {(ELEM_W-1){1'b1}}};
  localparam logic [ELEM_W-1:0] ELEM_MIN = {1'b1, {(ELEM_W-1){1'b0}}};

  // adj[k] = m[MA]*m[MB] - m[MC]*m[MD], sign of the cofactor folded in
  localparam int unsigned MA [N_ELEM] = '{4, 7, 1, 6, 0, 3, 3, 6, 0};
  localparam int unsigned MB [N_ELEM] = '{8, 2, 5, 5, 8, 2, 7, 1, 4};
  localparam int unsigned MC [N_ELEM] = '{7, 1, 4, 3, 6, 0, 6, 0, 3};
  localparam int unsigned MD [N_ELEM] = '{5, 8, 2, 8, 2, 5, 4, 7, 1};

  typedef logic signed [ELEM_W-1:0] elem_t;
  typedef logic signed [PROD_W-1:0] prod_t;
  typedef logic signed [ADJ_W-1:0]  adj_t;
  typedef logic signed [PL_W-1:0]   pl_t;
  typedef logic signed [DET_W-1:0]  det_t;
  typedef logic [NUM_W-1:0]         num_t;
  typedef logic [DEN_W-1:0]         den_t;
  typedef logic [Q_W-1:0]           q_t;

  typedef struct packed {
    logic              vld;
    logic              sing;
    logic [N_ELEM-1:0] neg;
  } div_side_t;

endpackage

// ===== rtl/m3inv_div.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// m3inv_div
// nine-lane restoring divider, overflow check, then one quotient bit per stage, shared divisor
// ---------------------------------------------------------------------------
module m3inv_div (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  en,
  input  m3inv_pkg::num_t       num_i  [m3inv_pkg::N_ELEM],
  input  m3inv_pkg::den_t       den_i,
  input  m3inv_pkg::div_side_t  side_i,
  output m3inv_pkg::q_t         q_o    [m3inv_pkg::N_ELEM],
  output logic [m3inv_pkg::N_ELEM-1:0] ovf_o,
  output m3inv_pkg::div_side_t  side_o
);

  localparam int NS = m3inv_pkg::DIV_STEPS;
  localparam int NE = m3inv_pkg::N_ELEM;

  m3inv_pkg::num_t      rem_r  [NS][NE];
  m3inv_pkg::q_t        q_r    [NS][NE];
  logic [NE-1:0]        ovf_r  [NS];
  m3inv_pkg::den_t      den_r  [NS];
  m3inv_pkg::div_side_t side_r [NS];

  for (genvar s = 0; s < NS; s++) begin : g_step
    localparam int SH = m3inv_pkg::Q_W - s;
    localparam int QB = (s == 0) ? 0 : SH;

    m3inv_pkg::num_t              rem_in  [NE];
    m3inv_pkg::q_t                q_in    [NE];
    logic [NE-1:0]                ovf_in;
    m3inv_pkg::den_t              den_in;
    m3inv_pkg::div_side_t         side_in;
    logic [m3inv_pkg::CMP_W-1:0]  dsh;
    logic [m3inv_pkg::CMP_W-1:0]  diff    [NE];
    logic [NE-1:0]                ge;
    m3inv_pkg::num_t              rem_nxt [NE];
    m3inv_pkg::q_t                q_nxt   [NE];
    logic [NE-1:0]                ovf_nxt;

    if (s == 0) begin : g_src
      always_comb begin
        for (int k = 0; k < NE; k++) begin
          rem_in[k] = num_i[k];
          q_in[k]   = '0;
        end
        ovf_in  = '0;
        den_in  = den_i;
        side_in = side_i;
      end
    end else begin : g_src
      always_comb begin
        for (int k = 0; k < NE; k++) begin
          rem_in[k] = rem_r[s-1][k];
          q_in[k]   = q_r[s-1][k];
        end
        ovf_in  = ovf_r[s-1];
        den_in  = den_r[s-1];
        side_in = side_r[s-1];
      end
    end

    // first step only flags a quotient of 2^Q_W or more
    always_comb begin
      dsh = m3inv_pkg::CMP_W'(den_in) << SH;
      for (int k = 0; k < NE; k++) begin
        diff[k]    = m3inv_pkg::CMP_W'(rem_in[k]) - dsh;
        ge[k]      = m3inv_pkg::CMP_W'(rem_in[k]) >= dsh;
        rem_nxt[k] = rem_in[k];
        q_nxt[k]   = q_in[k];
        ovf_nxt[k] = ovf_in[k];
        if (s == 0) begin
          ovf_nxt[k] = ge[k];
        end else if (ge[k]) begin
          rem_nxt[k]    = diff[k][m3inv_pkg::NUM_W-1:0];
          q_nxt[k][QB]  = 1'b1;
        end
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        side_r[s].vld <= 1'b0;
      end else if (en) begin
        side_r[s] <= side_in;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        den_r[s] <= den_in;
        ovf_r[s] <= ovf_nxt;
        for (int k = 0; k < NE; k++) begin
          rem_r[s][k] <= rem_nxt[k];
          q_r[s][k]   <= q_nxt[k];
        end
      end
    end
  end

  always_comb begin
    for (int k = 0; k < NE; k++) begin
      q_o[k] = q_r[NS-1][k];
    end
    ovf_o  = ovf_r[NS-1];
    side_o = side_r[NS-1];
  end

endmodule

// ===== rtl/matrix3_inverse_adjugate.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// matrix3_inverse_adjugate
// 3x3 Q16.16 matrix inverse by adjugate over determinant, fully pipelined
// ---------------------------------------------------------------------------
// Takes one matrix word per clock and returns its inverse through a chain
// of stages: six stages form the products, the adjugate, the exact
// determinant and the divider operands, 33 stages of a restoring divider
// check for an oversized quotient and then produce one quotient bit each
// for all nine elements at once, and one stage saturates the result.
// Throughput is one matrix per cycle; back-pressure on the output freezes
// the whole pipe. A zero determinant gives all-zero elements with singular
// set; saturated marks any element clipped to the Q16.16 range.
// ---------------------------------------------------------------------------
`include "matrix3_inverse_adjugate_macros.svh"

module matrix3_inverse_adjugate (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  // a00, a01, a02, a10, a11, a12, a20, a21, a22, 32 bits each
  input  logic [m3inv_pkg::TDATA_W-1:0]   in_tdata,
  output logic                            out_tvalid,
  input  logic                            out_tready,
  // inv00, inv01, inv02, inv10, inv11, inv12, inv20, inv21, inv22, 32 bits each
  output logic [m3inv_pkg::TDATA_W-1:0]   out_tdata,
  // singular, saturated
  output logic [m3inv_pkg::TUSER_W-1:0]   out_tuser
);

  localparam int NE = m3inv_pkg::N_ELEM;
  localparam int NR = m3inv_pkg::N_ROW;
  localparam int EW = m3inv_pkg::ELEM_W;

  logic en;

  m3inv_pkg::elem_t m [NE];

  // stage 1: element products
  m3inv_pkg::prod_t p1_r [NE];
  m3inv_pkg::prod_t p2_r [NE];
  m3inv_pkg::elem_t r0_s1_r [NR];
  logic             v1_r;
  // stage 2: adjugate
  m3inv_pkg::adj_t  adj_s2_r [NE];
  m3inv_pkg::elem_t r0_s2_r [NR];
  logic             v2_r;
  // stage 3: split determinant products
  m3inv_pkg::prod_t ph_r [NR];
  m3inv_pkg::pl_t   pl_r [NR];
  m3inv_pkg::adj_t  adj_s3_r [NE];
  logic             v3_r;
  // stage 4: determinant terms
  m3inv_pkg::det_t  term_r [NR];
  m3inv_pkg::adj_t  adj_s4_r [NE];
  logic             v4_r;
  // stage 5: determinant
  m3inv_pkg::det_t  det_r;
  m3inv_pkg::adj_t  adj_s5_r [NE];
  logic             v5_r;
  // stage 6: magnitudes and signs
  m3inv_pkg::num_t      num_r [NE];
  m3inv_pkg::den_t      den_r;
  m3inv_pkg::div_side_t side6_r;
  logic                 v6_r;

  m3inv_pkg::q_t        q_div [NE];
  logic [NE-1:0]        ovf_div;
  m3inv_pkg::div_side_t side_div;

  logic                   det_neg;
  m3inv_pkg::den_t        den_nxt;
  m3inv_pkg::num_t        num_nxt [NE];
  logic [NE-1:0]          neg_nxt;
  m3inv_pkg::div_side_t   side6_nxt;
  m3inv_pkg::adj_t        adj_abs [NE];

  logic [NE-1:0]          sat_k;
  logic [EW-1:0]          val_k [NE];
  logic [m3inv_pkg::TDATA_W-1:0] out_data_nxt;
  logic                   out_sat_nxt;
  logic                   out_vld_r;
  logic [m3inv_pkg::TDATA_W-1:0] out_data_r;
  logic [m3inv_pkg::TUSER_W-1:0] out_user_r;

  assign en        = !out_vld_r || out_tready;
  assign in_tready = en;

  always_comb begin
    for (int k = 0; k < NE; k++) begin
      m[k] = m3inv_pkg::elem_t'(in_tdata[k*EW +: EW]);
    end
  end

  // valid chain
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
      v5_r <= 1'b0;
      v6_r <= 1'b0;
    end else if (en) begin
      v1_r <= in_tvalid;
      v2_r <= v1_r;
      v3_r <= v2_r;
      v4_r <= v3_r;
      v5_r <= v4_r;
      v6_r <= v5_r;
    end
  end

  // magnitude and sign prep for the divider
  always_comb begin
    det_neg = det_r[m3inv_pkg::DET_W-1];
    den_nxt = det_neg ? m3inv_pkg::den_t'(-det_r) : m3inv_pkg::den_t'(det_r);
    for (int k = 0; k < NE; k++) begin
      adj_abs[k] = adj_s5_r[k][m3inv_pkg::ADJ_W-1] ? -adj_s5_r[k] : adj_s5_r[k];
      num_nxt[k] = m3inv_pkg::num_t'(unsigned'(adj_abs[k])) << (2 * m3inv_pkg::FRAC_W);
      neg_nxt[k] = adj_s5_r[k][m3inv_pkg::ADJ_W-1] ^ det_neg;
    end
    side6_nxt.vld  = v5_r;
    side6_nxt.sing = (det_r == '0);
    side6_nxt.neg  = neg_nxt;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < NE; k++) begin
        p1_r[k] <= m[m3inv_pkg::MA[k]] * m[m3inv_pkg::MB[k]];
        p2_r[k] <= m[m3inv_pkg::MC[k]] * m[m3inv_pkg::MD[k]];
        adj_s2_r[k] <= m3inv_pkg::ADJ_W'(p1_r[k]) - m3inv_pkg::ADJ_W'(p2_r[k]);
        adj_s3_r[k] <= adj_s2_r[k];
        adj_s4_r[k] <= adj_s3_r[k];
        adj_s5_r[k] <= adj_s4_r[k];
        num_r[k]    <= num_nxt[k];
      end
      for (int j = 0; j < NR; j++) begin
        r0_s1_r[j] <= m[j];
        r0_s2_r[j] <= r0_s1_r[j];
        // row 0 times first adjugate column, adjugate cut into high and low parts
        ph_r[j] <= r0_s2_r[j] *
                   $signed(adj_s2_r[j*NR][m3inv_pkg::ADJ_W-1 -: EW]);
        pl_r[j] <= r0_s2_r[j] *
                   $signed({1'b0, adj_s2_r[j*NR][m3inv_pkg::ADJ_LO_W-1:0]});
        term_r[j] <= (m3inv_pkg::DET_W'(ph_r[j]) <<< m3inv_pkg::ADJ_LO_W) +
                     m3inv_pkg::DET_W'(pl_r[j]);
      end
      det_r   <= term_r[0] + term_r[1] + term_r[2];
      den_r   <= den_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      side6_r.vld <= 1'b0;
    end else if (en) begin
      side6_r <= side6_nxt;
    end
  end

  m3inv_div u_div (
    .clk    (clk),
    .rst_n  (rst_n),
    .en     (en),
    .num_i  (num_r),
    .den_i  (den_r),
    .side_i (side6_r),
    .q_o    (q_div),
    .ovf_o  (ovf_div),
    .side_o (side_div)
  );

  // saturation and sign
  always_comb begin
    out_data_nxt = '0;
    for (int k = 0; k < NE; k++) begin
      if (side_div.neg[k]) begin
        sat_k[k] = ovf_div[k] || (q_div[k][EW-1] && (q_div[k][EW-2:0] != '0));
        val_k[k] = sat_k[k] ? m3inv_pkg::ELEM_MIN : -q_div[k];
      end else begin
        sat_k[k] = ovf_div[k] || q_div[k][EW-1];
        val_k[k] = sat_k[k] ? m3inv_pkg::ELEM_MAX : q_div[k];
      end
      out_data_nxt[k*EW +: EW] = val_k[k];
    end
    out_sat_nxt = |sat_k;
    if (side_div.sing) begin
      out_data_nxt = '0;
      out_sat_nxt  = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (en) begin
      out_vld_r <= side_div.vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_data_r <= out_data_nxt;
      out_user_r <= {out_sat_nxt, side_div.sing};
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_user_r;

  `M3INV_ASSERT_SAME(a_sing_zero, out_tvalid && out_tuser[0], out_tdata == '0 && !out_tuser[1])
  `M3INV_ASSERT_SAME(a_ready_free, !out_tvalid, in_tready)
  `M3INV_ASSERT_NEXT(a_stall_hold, out_tvalid && !out_tready, $stable({v1_r, v2_r, v3_r, v4_r, v5_r, v6_r}))

endmodule

// ===== tb/tb_matrix3_inverse_adjugate.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_matrix3_inverse_adjugate
// self-checking bench for the pipelined 3x3 fixed-point inverse
// ---------------------------------------------------------------------------
// Sends matrix words in bursts against a receiver with its own stall
// pattern, including one long hold-off that fills the pipe. A directed
// table covers identity, zero, extreme and saturating matrices. Random
// words follow: full-range, small, singular and extreme-valued. Typed
// rows carry their result, other words are predicted in exact wide
// arithmetic; each is checked per element against results in order.
// ---------------------------------------------------------------------------
module tb_matrix3_inverse_adjugate;

  localparam int TDATA_W  = m3inv_pkg::TDATA_W;
  localparam int TUSER_W  = m3inv_pkg::TUSER_W;
  localparam int ELEM_W   = m3inv_pkg::ELEM_W;
  localparam int FRAC_W   = m3inv_pkg::FRAC_W;
  localparam logic [ELEM_W-1:0] ELEM_MAX = m3inv_pkg::ELEM_MAX;
  localparam logic [ELEM_W-1:0] ELEM_MIN = m3inv_pkg::ELEM_MIN;

  localparam int N_RANDOM = 1800;
  localparam int LIMIT    = 600000;
  localparam int DRAIN    = 60;

  typedef m3inv_pkg::elem_t elem_t;
  typedef logic signed [127:0] wide_t;

  typedef struct {
    logic [TDATA_W-1:0] data;
    logic [TUSER_W-1:0] user;
  } inv_word_t;

  typedef struct {
    logic [TDATA_W-1:0] mat;
    logic               typed;
    logic [TDATA_W-1:0] inv;
    logic [TUSER_W-1:0] flags;
  } row_t;

  logic               clk;
  logic               rst_n;
  logic               in_tvalid;
  logic               in_tready;
  logic [TDATA_W-1:0] in_tdata;
  logic               out_tvalid;
  logic               out_tready;
  logic [TDATA_W-1:0] out_tdata;
  logic [TUSER_W-1:0] out_tuser;

  inv_word_t expected_inv[$];
  int        errors;
  int        words_in;
  int        words_out;
  int        n_singular;
  int        n_saturated;
  int        cycles;
  bit        sending_done;

  matrix3_inverse_adjugate dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready),
    .out_tdata(out_tdata), .out_tuser(out_tuser)
  );

  always begin
    clk = 1'b1; #5;
    clk = 1'b0; #5;
  end

  function automatic logic [TDATA_W-1:0] pack9(elem_t e0, elem_t e1, elem_t e2,
                                                elem_t e3, elem_t e4, elem_t e5,
                                                elem_t e6, elem_t e7, elem_t e8);
    return {e8, e7, e6, e5, e4, e3, e2, e1, e0};
  endfunction

  // exact adjugate over determinant, truncated and saturated
  function automatic inv_word_t invert3(logic [TDATA_W-1:0] mat);
    wide_t     m[9];
    wide_t     adj[9];
    wide_t     det;
    wide_t     mag;
    wide_t     q;
    logic      neg;
    logic      sat;
    inv_word_t r;
    for (int i = 0; i < 9; i++) m[i] = elem_t'(mat[i*ELEM_W +: ELEM_W]);
    adj[0] =   m[4]*m[8] - m[7]*m[5];
    adj[1] = -(m[1]*m[8] - m[7]*m[2]);
    adj[2] =   m[1]*m[5] - m[4]*m[2];
    adj[3] = -(m[3]*m[8] - m[6]*m[5]);
    adj[4] =   m[0]*m[8] - m[6]*m[2];
    adj[5] = -(m[0]*m[5] - m[3]*m[2]);
    adj[6] =   m[3]*m[7] - m[6]*m[4];
    adj[7] = -(m[0]*m[7] - m[6]*m[1]);
    adj[8] =   m[0]*m[4] - m[3]*m[1];
    det = m[0]*adj[0] + m[1]*adj[3] + m[2]*adj[6];
    r.data = '0;
    if (det == 0) begin
      r.user = 2'b01;
      return r;
    end
    sat = 1'b0;
    for (int k = 0; k < 9; k++) begin
      neg = adj[k][127] != det[127];
      mag = adj[k][127] ? -adj[k] : adj[k];
      q = $unsigned(mag << (2*FRAC_W)) / $unsigned(det[127] ? -det : det);
      if (!neg) begin
        if (q > wide_t'(ELEM_MAX)) begin
          sat = 1'b1;
          r.data[k*ELEM_W +: ELEM_W] = ELEM_MAX;
        end else begin
          r.data[k*ELEM_W +: ELEM_W] = q[ELEM_W-1:0];
        end
      end else begin
        if (q > wide_t'({1'b0, ELEM_MIN})) begin
          sat = 1'b1;
          r.data[k*ELEM_W +: ELEM_W] = ELEM_MIN;
        end else begin
          r.data[k*ELEM_W +: ELEM_W] = -q[ELEM_W-1:0];
        end
      end
    end
    r.user = {sat, 1'b0};
    return r;
  endfunction

  function automatic elem_t pick_elem(int kind);
    int sel;
    case (kind)
      1: return elem_t'($signed($urandom_range(0, 16)) - 8) <<< FRAC_W
                | elem_t'($urandom_range(0, 255));
      3: begin
        sel = $urandom_range(0, 6);
        case (sel)
          0: return ELEM_MAX;
          1: return ELEM_MIN;
          2: return '0;
          3: return elem_t'(1);
          4: return -elem_t'(1);
          5: return elem_t'(32'h0001_0000);
          default: return elem_t'($urandom);
        endcase
      end
      default: return elem_t'($urandom);
    endcase
  endfunction

  function automatic logic [TDATA_W-1:0] random_matrix();
    elem_t e[9];
    int    kind;
    int    r;
    kind = $urandom_range(0, 9);
    for (int i = 0; i < 9; i++)
      e[i] = pick_elem(kind < 3 ? 0 : kind < 6 ? 1 : kind < 8 ? 3 : 1);
    // rank-deficient case: copy one row or column onto another
    if (kind >= 8) begin
      r = $urandom_range(0, 2);
      if (kind == 8) begin
        for (int c = 0; c < 3; c++) e[((r + 1) % 3)*3 + c] = e[r*3 + c];
      end else begin
        for (int c = 0; c < 3; c++) e[c*3 + (r + 1) % 3] = e[c*3 + r];
      end
    end
    return pack9(e[0], e[1], e[2], e[3], e[4], e[5], e[6], e[7], e[8]);
  endfunction

  task automatic send_word(logic [TDATA_W-1:0] mat, inv_word_t exp_word);
    in_tdata  <= mat;
    in_tvalid <= 1'b1;
    do @(posedge clk); while (!in_tready);
    expected_inv.push_back(exp_word);
    words_in++;
  endtask

  initial begin
    row_t         rows[$];
    row_t         row;
    inv_word_t    w;
    int           burst;
    int           gap;
    elem_t        one;
    logic [TDATA_W-1:0] mat;
    one = elem_t'(32'h0001_0000);
    rst_n        = 1'b0;
    in_tvalid    = 1'b0;
    in_tdata     = '0;
    errors       = 0;
    words_in     = 0;
    sending_done = 1'b0;

    // typed rows: identity, zero, diagonal extremes, all-MAX and all-MIN
    rows.push_back('{pack9(one, 0, 0, 0, one, 0, 0, 0, one), 1'b1,
                     pack9(one, 0, 0, 0, one, 0, 0, 0, one), 2'b00});
    rows.push_back('{'0, 1'b1, '0, 2'b01});
    rows.push_back('{pack9(ELEM_MIN, 0, 0, 0, ELEM_MIN, 0, 0, 0, ELEM_MIN), 1'b1,
                     pack9(-2, 0, 0, 0, -2, 0, 0, 0, -2), 2'b00});
    rows.push_back('{pack9(1, 0, 0, 0, 1, 0, 0, 0, 1), 1'b1,
                     pack9(ELEM_MAX, 0, 0, 0, ELEM_MAX, 0, 0, 0, ELEM_MAX), 2'b10});
    rows.push_back('{pack9(-1, 0, 0, 0, -1, 0, 0, 0, -1), 1'b1,
                     pack9(ELEM_MIN, 0, 0, 0, ELEM_MIN, 0, 0, 0, ELEM_MIN), 2'b10});
    rows.push_back('{{9{ELEM_MAX}}, 1'b1, '0, 2'b01});
    rows.push_back('{{9{ELEM_MIN}}, 1'b1, '0, 2'b01});
    // predicted rows
    rows.push_back('{pack9(-one, 0, 0, 0, -one, 0, 0, 0, -one), 1'b0, '0, '0});
    rows.push_back('{pack9(0, one, 0, 0, 0, one, one, 0, 0), 1'b0, '0, '0});
    rows.push_back('{pack9(ELEM_MAX, 0, 0, 0, ELEM_MAX, 0, 0, 0, ELEM_MAX),
                     1'b0, '0, '0});
    rows.push_back('{pack9(ELEM_MAX, ELEM_MIN, 0, ELEM_MIN, ELEM_MAX, 0, 0, 0, one),
                     1'b0, '0, '0});
    rows.push_back('{pack9(ELEM_MIN, ELEM_MAX, ELEM_MIN, ELEM_MAX, ELEM_MIN,
                           ELEM_MAX, ELEM_MIN, ELEM_MAX, ELEM_MAX), 1'b0, '0, '0});
    rows.push_back('{pack9(2*one, one, 0, one, 2*one, one, 0, one, 2*one),
                     1'b0, '0, '0});
    rows.push_back('{pack9(one, 2*one, 3*one, 4*one, 5*one, 6*one, 7*one, 8*one,
                           10*one), 1'b0, '0, '0});
    rows.push_back('{pack9(3, 0, 0, 0, 7, 0, 0, 0, -5), 1'b0, '0, '0});
    rows.push_back('{{9{32'hFFFF_FFFF}}, 1'b0, '0, '0});
    rows.push_back('{{9{32'h5555_5555}}, 1'b0, '0, '0});
    rows.push_back('{pack9(32'hAAAA_AAAA, 32'h5555_5555, 0, 0, 32'hAAAA_AAAA,
                           32'h5555_5555, 32'h5555_5555, 0, 32'hAAAA_AAAA),
                     1'b0, '0, '0});

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (rows[i]) begin
      row = rows[i];
      if (row.typed) begin
        w.data = row.inv;
        w.user = row.flags;
      end else begin
        w = invert3(row.mat);
      end
      send_word(row.mat, w);
    end

    for (int n = 0; n < N_RANDOM; ) begin
      burst = $urandom_range(1, 40);
      for (int b = 0; b < burst && n < N_RANDOM; b++, n++) begin
        mat = random_matrix();
        send_word(mat, invert3(mat));
      end
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        in_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    in_tvalid <= 1'b0;
    sending_done = 1'b1;
  end

  // receiver: runs of random ready density, one long hold-off
  initial begin
    int  run;
    int  density;
    bit  held;
    held       = 1'b0;
    out_tready = 1'b0;
    @(posedge clk iff rst_n);
    forever begin
      if (!held && words_in >= 600) begin
        held = 1'b1;
        out_tready <= 1'b0;
        repeat (300) @(posedge clk);
      end else begin
        run     = $urandom_range(1, 40);
        density = $urandom_range(0, 4);
        repeat (run) begin
          out_tready <= (density == 4) ? 1'b1 : ($urandom_range(0, 3) < density + 1);
          @(posedge clk);
        end
      end
    end
  end

  always @(posedge clk) begin
    inv_word_t e;
    if (rst_n && out_tvalid && out_tready) begin
      words_out++;
      if (expected_inv.size() == 0) begin
        errors++;
        $display("%0t: unexpected result word %h / %b", $time, out_tdata, out_tuser);
      end else begin
        e = expected_inv.pop_front();
        n_singular  += e.user[0];
        n_saturated += e.user[1];
        for (int k = 0; k < 9; k++) begin
          if (out_tdata[k*ELEM_W +: ELEM_W] !== e.data[k*ELEM_W +: ELEM_W]) begin
            errors++;
            $display("%0t: inv%0d%0d expected %h actual %h", $time, k / 3, k % 3,
                     e.data[k*ELEM_W +: ELEM_W], out_tdata[k*ELEM_W +: ELEM_W]);
          end
        end
        if (out_tuser[0] !== e.user[0]) begin
          errors++;
          $display("%0t: singular expected %b actual %b", $time, e.user[0], out_tuser[0]);
        end
        if (out_tuser[1] !== e.user[1]) begin
          errors++;
          $display("%0t: saturated expected %b actual %b", $time, e.user[1],
                   out_tuser[1]);
        end
      end
    end
  end

  initial begin
    words_out   = 0;
    n_singular  = 0;
    n_saturated = 0;
    cycles      = 0;
    fork
      begin
        wait (sending_done);
        while (expected_inv.size() != 0) @(posedge clk);
        repeat (DRAIN) @(posedge clk);
      end
      begin
        while (cycles < LIMIT) begin
          @(posedge clk);
          cycles++;
        end
        $display("%0t: timeout, %0d results still pending", $time, expected_inv.size());
        $display("FAIL");
        $finish;
      end
    join_any
    $display("%0d matrices sent, %0d inverses checked in %0d cycles", words_in,
             words_out, cycles);
    $display("%0d singular, %0d saturated, %0d mismatches", n_singular, n_saturated,
             errors);
    if (errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
